/* rtl/tcf_pkg.sv */
package tcf_pkg;

  // Panel geometry in raw controller units.
  localparam int unsigned PANEL_LONG  = 640;
  localparam int unsigned PANEL_SHORT = 172;

  // Field widths.
  localparam int unsigned RAW_W   = 12;
  localparam int unsigned PX_W    = 8;
  localparam int unsigned PY_W    = 10;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned GAP_W   = 20;
  localparam int unsigned LIM_W   = 10;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 20;

  // Motion allowance grows with the time since the last accepted point.
  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned MS_CAP      = 200;
  localparam int unsigned MS_FREE     = 10;
  localparam int unsigned ALLOW_SLOPE = 2;
  localparam int unsigned ALLOW_W     = 9;

  // Millisecond conversion: the gap is only converted while it lies below the cap,
  // so it fits in MS_IN_W bits. The low three bits are dropped (1000 = 8 * 125) and
  // the rest is multiplied by a rounded-up reciprocal of 125.
  localparam int unsigned MS_IN_W    = 18;
  localparam int unsigned MS_PRE_SH  = 3;
  localparam int unsigned MS_DIV     = US_PER_MS >> MS_PRE_SH;
  localparam int unsigned MS_SHIFT   = 24;
  localparam int unsigned MS_RECIP   = ((1 << MS_SHIFT) + MS_DIV - 1) / MS_DIV;
  localparam int unsigned MS_RECIP_W = 18;
  localparam int unsigned MS_NUM_W   = MS_IN_W - MS_PRE_SH;
  localparam int unsigned MS_PROD_W  = MS_NUM_W + MS_RECIP_W;

  // Contact event codes as reported by the controller.
  typedef enum logic [1:0] {
    EV_DOWN    = 2'd0,
    EV_UP      = 2'd1,
    EV_CONTACT = 2'd2,
    EV_NONE    = 2'd3
  } event_t;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_RELEASE_GAP    = 3'd0,
    REG_CONFIRM_WINDOW = 3'd1,
    REG_JUMP_X         = 3'd2,
    REG_JUMP_Y         = 3'd3,
    REG_CONFIRM_X      = 3'd4,
    REG_CONFIRM_Y      = 3'd5
  } reg_idx_t;

  // What the selected contact asks of the tracker.
  typedef enum logic [1:0] {
    SEL_MISS,
    SEL_CLEAR,
    SEL_TRACK
  } sel_kind_t;

  typedef struct packed {
    logic [GAP_W-1:0] release_gap_us;
    logic [GAP_W-1:0] confirm_window_us;
    logic [LIM_W-1:0] jump_limit_x;
    logic [LIM_W-1:0] jump_limit_y;
    logic [LIM_W-1:0] confirm_limit_x;
    logic [LIM_W-1:0] confirm_limit_y;
  } cfg_t;

  typedef struct packed {
    sel_kind_t       kind;
    logic [PX_W-1:0] x;
    logic [PY_W-1:0] y;
  } contact_t;

  typedef struct packed {
    logic            held;
    logic [PX_W-1:0] x;
    logic [PY_W-1:0] y;
  } last_pt_t;

  typedef struct packed {
    logic            is_pressed;
    logic [PX_W-1:0] x;
    logic [PY_W-1:0] y;
  } result_t;

  function automatic logic [PX_W-1:0] absdiff_x(input logic [PX_W-1:0] a,
                                                input logic [PX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [PY_W-1:0] absdiff_y(input logic [PY_W-1:0] a,
                                                input logic [PY_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

/* rtl/tcf_cfg_regs.sv */
module tcf_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tcf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tcf_pkg::DATA_W-1:0] cfg_data,
  output tcf_pkg::cfg_t              cfg
);
  import tcf_pkg::*;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.release_gap_us    <= GAP_W'(25000);
      cfg.confirm_window_us <= GAP_W'(40000);
      cfg.jump_limit_x      <= LIM_W'(48);
      cfg.jump_limit_y      <= LIM_W'(96);
      cfg.confirm_limit_x   <= LIM_W'(24);
      cfg.confirm_limit_y   <= LIM_W'(48);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RELEASE_GAP:    cfg.release_gap_us    <= cfg_data;
        REG_CONFIRM_WINDOW: cfg.confirm_window_us <= cfg_data;
        REG_JUMP_X:         cfg.jump_limit_x      <= cfg_data[LIM_W-1:0];
        REG_JUMP_Y:         cfg.jump_limit_y      <= cfg_data[LIM_W-1:0];
        REG_CONFIRM_X:      cfg.confirm_limit_x   <= cfg_data[LIM_W-1:0];
        REG_CONFIRM_Y:      cfg.confirm_limit_y   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tcf_point_sel.sv */
module tcf_point_sel (
  input  logic                        read_ok,
  input  logic [tcf_pkg::COUNT_W-1:0] contact_count,
  input  logic [tcf_pkg::RAW_W-1:0]   first_raw_x,
  input  logic [tcf_pkg::RAW_W-1:0]   first_raw_y,
  input  logic [1:0]                  first_event,
  input  logic [tcf_pkg::RAW_W-1:0]   second_raw_x,
  input  logic [tcf_pkg::RAW_W-1:0]   second_raw_y,
  input  logic [1:0]                  second_event,
  input  tcf_pkg::last_pt_t           last_pt,
  output tcf_pkg::contact_t           contact
);
  import tcf_pkg::*;

  localparam logic [PY_W-1:0] Y_MAX = PY_W'(PANEL_LONG - 1);
  localparam int unsigned     DIST_W = PY_W + 1;

  logic            a_val, b_val, take_b, k_val;
  logic [PX_W-1:0] ax, bx, kx;
  logic [PY_W-1:0] ay, by, ky;
  event_t          k_ev;
  logic [DIST_W-1:0] dist_a, dist_b;

  // Rotate both records into screen space and check them against the panel.
  assign a_val = (first_raw_x < RAW_W'(PANEL_LONG)) && (first_raw_y < RAW_W'(PANEL_SHORT));
  assign b_val = (second_raw_x < RAW_W'(PANEL_LONG)) && (second_raw_y < RAW_W'(PANEL_SHORT));
  assign ax = first_raw_y[PX_W-1:0];
  assign ay = Y_MAX - first_raw_x[PY_W-1:0];
  assign bx = second_raw_y[PX_W-1:0];
  assign by = Y_MAX - second_raw_x[PY_W-1:0];

  // Manhattan distance of each record to the last point.
  assign dist_a = DIST_W'(absdiff_x(ax, last_pt.x)) + DIST_W'(absdiff_y(ay, last_pt.y));
  assign dist_b = DIST_W'(absdiff_x(bx, last_pt.x)) + DIST_W'(absdiff_y(by, last_pt.y));

  // With two contacts, fall back to the second one when the first is off panel,
  // and otherwise keep the nearer one while a press is held.
  always_comb begin
    take_b = 1'b0;
    if (contact_count == COUNT_W'(2)) begin
      if (!a_val) begin
        take_b = 1'b1;
      end else if (b_val && last_pt.held) begin
        take_b = dist_b < dist_a;
      end
    end
  end

  assign kx    = take_b ? bx : ax;
  assign ky    = take_b ? by : ay;
  assign k_val = take_b ? b_val : a_val;
  assign k_ev  = event_t'(take_b ? second_event : first_event);

  // Classify the transaction for the tracker.
  always_comb begin
    contact.x = kx;
    contact.y = ky;
    priority if (!read_ok) begin
      contact.kind = SEL_MISS;
    end else if (contact_count == '0) begin
      contact.kind = SEL_CLEAR;
    end else if (contact_count > COUNT_W'(2)) begin
      contact.kind = SEL_MISS;
    end else if (!k_val || k_ev == EV_NONE) begin
      contact.kind = SEL_MISS;
    end else if (k_ev == EV_UP) begin
      contact.kind = SEL_CLEAR;
    end else begin
      contact.kind = SEL_TRACK;
    end
  end

endmodule

/* rtl/tcf_track.sv */
module tcf_track (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  tcf_pkg::contact_t          contact,
  input  logic [tcf_pkg::TIME_W-1:0] time_us,
  input  tcf_pkg::cfg_t              cfg,
  output tcf_pkg::last_pt_t          last_pt,
  output tcf_pkg::result_t           result
);
  import tcf_pkg::*;

  localparam int unsigned SGAP_W = TIME_W + 1;
  localparam int unsigned LIMA_W = LIM_W + 1;
  localparam logic [SGAP_W-1:0] GAP_FREE = SGAP_W'((MS_FREE + 1) * US_PER_MS);
  localparam logic [SGAP_W-1:0] GAP_CAP  = SGAP_W'((MS_CAP + 1) * US_PER_MS);
  localparam logic [ALLOW_W-1:0] ALLOW_MAX = ALLOW_W'((MS_CAP - MS_FREE) * ALLOW_SLOPE);

  // Tracker state.
  logic [PX_W-1:0]   last_x, pending_x;
  logic [PY_W-1:0]   last_y, pending_y;
  logic [TIME_W-1:0] last_valid_time, pending_time;
  logic              contact_held, pending_flag;

  logic [PX_W-1:0]   last_x_next, pending_x_next;
  logic [PY_W-1:0]   last_y_next, pending_y_next;
  logic [TIME_W-1:0] last_valid_time_next, pending_time_next;
  logic              contact_held_next, pending_flag_next;

  logic signed [SGAP_W-1:0] gap_last, gap_pend;
  logic                     hold;
  logic [MS_PROD_W-1:0]     ms_prod;
  logic [PX_W-1:0]          ms;
  logic [ALLOW_W-1:0]       allow;
  logic [LIMA_W-1:0]        lim_x, lim_y;
  logic                     jump, confirmed;

  assign last_pt.held = contact_held;
  assign last_pt.x    = last_x;
  assign last_pt.y    = last_y;

  // Signed time differences against the last point and the pending point.
  assign gap_last = $signed({1'b0, time_us}) - $signed({1'b0, last_valid_time});
  assign gap_pend = $signed({1'b0, time_us}) - $signed({1'b0, pending_time});

  // The press survives a missing sample while the gap stays within the release gap.
  assign hold = contact_held &&
                (gap_last <= $signed({{(SGAP_W-GAP_W){1'b0}}, cfg.release_gap_us}));

  // Elapsed milliseconds by reciprocal multiply; only used between the two bounds.
  assign ms_prod = MS_PROD_W'(gap_last[MS_IN_W-1:MS_PRE_SH]) *
                   MS_PROD_W'(MS_RECIP_W'(MS_RECIP));
  assign ms      = ms_prod[MS_SHIFT +: PX_W];

  // Extra motion allowance for a slow sample.
  always_comb begin
    priority if (gap_last < $signed(GAP_FREE)) begin
      allow = '0;
    end else if (gap_last >= $signed(GAP_CAP)) begin
      allow = ALLOW_MAX;
    end else begin
      allow = ALLOW_W'(ms - PX_W'(MS_FREE)) * ALLOW_W'(ALLOW_SLOPE);
    end
  end

  assign lim_x = LIMA_W'(cfg.jump_limit_x) + LIMA_W'(allow);
  assign lim_y = LIMA_W'(cfg.jump_limit_y) + LIMA_W'(allow);

  // A first contact or a large jump needs a confirming sample.
  assign jump = !contact_held ||
                (LIMA_W'(absdiff_x(contact.x, last_x)) > lim_x) ||
                (LIMA_W'(absdiff_y(contact.y, last_y)) > lim_y);

  assign confirmed = pending_flag &&
      (gap_pend <= $signed({{(SGAP_W-GAP_W){1'b0}}, cfg.confirm_window_us})) &&
      (LIM_W'(absdiff_x(contact.x, pending_x)) <= cfg.confirm_limit_x) &&
      (absdiff_y(contact.y, pending_y) <= cfg.confirm_limit_y);

  // Next state and result for the current transaction.
  always_comb begin
    last_x_next          = last_x;
    last_y_next          = last_y;
    last_valid_time_next = last_valid_time;
    contact_held_next    = hold;
    pending_flag_next    = pending_flag;
    pending_x_next       = pending_x;
    pending_y_next       = pending_y;
    pending_time_next    = pending_time;
    result.is_pressed    = hold;
    result.x             = last_x;
    result.y             = last_y;
    unique case (contact.kind)
      SEL_CLEAR: begin
        pending_flag_next = 1'b0;
      end
      SEL_TRACK: begin
        if (jump && !confirmed) begin
          // Park the point until a nearby sample confirms it.
          pending_flag_next = 1'b1;
          pending_x_next    = contact.x;
          pending_y_next    = contact.y;
          pending_time_next = time_us;
        end else begin
          pending_flag_next    = 1'b0;
          last_x_next          = contact.x;
          last_y_next          = contact.y;
          last_valid_time_next = time_us;
          contact_held_next    = 1'b1;
          result.is_pressed    = 1'b1;
          result.x             = contact.x;
          result.y             = contact.y;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x          <= '0;
      last_y          <= '0;
      last_valid_time <= '0;
      contact_held    <= 1'b0;
      pending_flag    <= 1'b0;
      pending_x       <= '0;
      pending_y       <= '0;
      pending_time    <= '0;
    end else if (fire) begin
      last_x          <= last_x_next;
      last_y          <= last_y_next;
      last_valid_time <= last_valid_time_next;
      contact_held    <= contact_held_next;
      pending_flag    <= pending_flag_next;
      pending_x       <= pending_x_next;
      pending_y       <= pending_y_next;
      pending_time    <= pending_time_next;
    end
  end

endmodule

/* rtl/touch_contact_filter.sv */
// Channel   Handshake                Payload
// in        in_valid / in_stall      read_ok, contact_count, first_*, second_*, time_us
// out       out_valid / out_stall    is_pressed, point_x, point_y
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One result per poll transaction, one transaction per cycle when out is not stalled.
// A transaction passes an input register, then the filter logic into the result register.
// The filter state updates in the cycle a transaction moves into the result register.
// rst is synchronous: it empties both registers and restores state and register defaults.
// A stalled result holds; in_stall rises only while both registers are full.
module touch_contact_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        read_ok,
  input  logic [tcf_pkg::COUNT_W-1:0] contact_count,
  input  logic [tcf_pkg::RAW_W-1:0]   first_raw_x,
  input  logic [tcf_pkg::RAW_W-1:0]   first_raw_y,
  input  logic [1:0]                  first_event,
  input  logic [tcf_pkg::RAW_W-1:0]   second_raw_x,
  input  logic [tcf_pkg::RAW_W-1:0]   second_raw_y,
  input  logic [1:0]                  second_event,
  input  logic [tcf_pkg::TIME_W-1:0]  time_us,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        is_pressed,
  output logic [tcf_pkg::PX_W-1:0]    point_x,
  output logic [tcf_pkg::PY_W-1:0]    point_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcf_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tcf_pkg::DATA_W-1:0]  cfg_data
);
  import tcf_pkg::*;

  // Input register.
  logic                s1_valid;
  logic                s1_read_ok;
  logic [COUNT_W-1:0]  s1_count;
  logic [RAW_W-1:0]    s1_ax, s1_ay, s1_bx, s1_by;
  logic [1:0]          s1_aev, s1_bev;
  logic [TIME_W-1:0]   s1_time;

  logic      fire, in_take;
  cfg_t      cfg;
  contact_t  contact;
  last_pt_t  last_pt;
  result_t   result;

  // The input register moves on whenever the result register is free or draining.
  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_read_ok <= read_ok;
      s1_count   <= contact_count;
      s1_ax      <= first_raw_x;
      s1_ay      <= first_raw_y;
      s1_aev     <= first_event;
      s1_bx      <= second_raw_x;
      s1_by      <= second_raw_y;
      s1_bev     <= second_event;
      s1_time    <= time_us;
    end
  end

  tcf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tcf_point_sel u_sel (
    .read_ok       (s1_read_ok),
    .contact_count (s1_count),
    .first_raw_x   (s1_ax),
    .first_raw_y   (s1_ay),
    .first_event   (s1_aev),
    .second_raw_x  (s1_bx),
    .second_raw_y  (s1_by),
    .second_event  (s1_bev),
    .last_pt       (last_pt),
    .contact       (contact)
  );

  tcf_track u_track (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .contact (contact),
    .time_us (s1_time),
    .cfg     (cfg),
    .last_pt (last_pt),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      is_pressed <= result.is_pressed;
      point_x    <= result.x;
      point_y    <= result.y;
    end
  end

endmodule
